### hw/rtl/f2i_pkg.sv
package f2i_pkg;

  localparam logic [1:0] KIND_SINGLE   = 2'd0;
  localparam logic [1:0] KIND_DOUBLE   = 2'd1;
  localparam logic [1:0] KIND_EXTENDED = 2'd2;

  localparam logic [14:0] SGL_EXP_MAX = 15'h00ff;
  localparam logic [14:0] DBL_EXP_MAX = 15'h07ff;
  localparam logic [14:0] EXT_EXP_MAX = 15'h7fff;

  // bias plus fraction width
  localparam logic signed [15:0] SGL_SHIFT_BIAS = 16'sd150;
  localparam logic signed [15:0] DBL_SHIFT_BIAS = 16'sd1075;
  localparam logic signed [15:0] EXT_SHIFT_BIAS = 16'sd16446;

  localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SMAX64   = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic                unused;
    logic                smode;
    logic                neg;
    logic                zero_ex;
    logic                max_ex;
    logic                inf;
    logic [63:0]         mant;
    logic signed [15:0]  e;
  } dec_t;

  typedef struct packed {
    logic        unused;
    logic        smode;
    logic        neg;
    logic        max_ex;
    logic        inf;
    logic [63:0] mag;
  } mag_t;

endpackage

### hw/rtl/f2i_decode.sv
module f2i_decode (
  input  logic [1:0]     kind,
  input  logic           signed_mode,
  input  logic [63:0]    mantissa_word,
  input  logic [15:0]    sign_exponent,
  output f2i_pkg::dec_t  dec
);

  logic [14:0]        ex;
  logic [14:0]        emax;
  logic signed [15:0] bias;

  always_comb begin
    dec = '0;
    ex = '0;
    emax = f2i_pkg::EXT_EXP_MAX;
    bias = f2i_pkg::EXT_SHIFT_BIAS;
    dec.smode = signed_mode;
    unique case (kind)
      f2i_pkg::KIND_SINGLE: begin
        dec.neg = mantissa_word[31];
        ex = {7'd0, mantissa_word[30:23]};
        emax = f2i_pkg::SGL_EXP_MAX;
        bias = f2i_pkg::SGL_SHIFT_BIAS;
        dec.mant = {40'd0, 1'b1, mantissa_word[22:0]};
        dec.inf = (mantissa_word[22:0] == 23'd0);
      end
      f2i_pkg::KIND_DOUBLE: begin
        dec.neg = mantissa_word[63];
        ex = {4'd0, mantissa_word[62:52]};
        emax = f2i_pkg::DBL_EXP_MAX;
        bias = f2i_pkg::DBL_SHIFT_BIAS;
        dec.mant = {11'd0, 1'b1, mantissa_word[51:0]};
        dec.inf = (mantissa_word[51:0] == 52'd0);
      end
      f2i_pkg::KIND_EXTENDED: begin
        dec.neg = sign_exponent[15];
        ex = sign_exponent[14:0];
        emax = f2i_pkg::EXT_EXP_MAX;
        bias = f2i_pkg::EXT_SHIFT_BIAS;
        dec.mant = mantissa_word;
        dec.inf = (mantissa_word == f2i_pkg::SIGN64);
      end
      default: begin
        dec.unused = 1'b1;
      end
    endcase
    dec.zero_ex = (ex == 15'd0);
    dec.max_ex = (ex == emax);
    dec.e = signed'({1'b0, ex}) - bias;
  end

endmodule

### hw/rtl/f2i_shift.sv
module f2i_shift (
  input  logic           clk,
  input  f2i_pkg::dec_t  dec,
  output f2i_pkg::mag_t  mag
);

  logic               e_pos;
  logic               e_big;
  logic               e_tiny;
  logic [5:0]         lamt;
  logic [15:0]        neg_e;
  logic [63:0]        shl;
  logic               ovf;
  logic [63:0]        shifted;
  f2i_pkg::mag_t      mag_next;

  always_comb begin
    e_pos = !dec.e[15] && (dec.e != 16'sd0);
    e_big = (dec.e > 16'sd63);
    e_tiny = (dec.e <= -16'sd64);
    lamt = dec.e[5:0];
    neg_e = 16'(-dec.e);
    shl = dec.mant << lamt;
    ovf = ((shl >> lamt) != dec.mant);
    if (e_pos) begin
      if (dec.mant == 64'd0) shifted = 64'd0;
      else if (e_big || ovf) shifted = f2i_pkg::ALL_ONES;
      else shifted = shl;
    end else if (e_tiny) begin
      shifted = 64'd0;
    end else begin
      shifted = dec.mant >> neg_e[5:0];
    end

    mag_next.unused = dec.unused;
    mag_next.smode = dec.smode;
    mag_next.neg = dec.neg;
    mag_next.max_ex = dec.max_ex;
    mag_next.inf = dec.inf;
    if (dec.zero_ex) mag_next.mag = 64'd0;
    else if (dec.max_ex) mag_next.mag = f2i_pkg::ALL_ONES;
    else mag_next.mag = shifted;
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
  end

endmodule

### hw/rtl/f2i_finish.sv
module f2i_finish (
  input  logic           clk,
  input  f2i_pkg::mag_t  mag,
  output logic [63:0]    result
);

  logic [63:0] result_next;

  always_comb begin
    if (mag.unused) begin
      result_next = 64'd0;
    end else if (!mag.smode) begin
      result_next = mag.neg ? 64'd0 : mag.mag;
    end else if (mag.neg && mag.max_ex && !mag.inf) begin
      result_next = 64'd0;
    end else if (mag.mag >= f2i_pkg::SIGN64) begin
      result_next = mag.neg ? f2i_pkg::SIGN64 : f2i_pkg::SMAX64;
    end else begin
      result_next = mag.neg ? (64'd0 - mag.mag) : mag.mag;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

### hw/rtl/float_to_int64_convert.sv
// Float to 64-bit integer converter.
// Each accepted word passes the input, shift and result registers before done is high.
// Throughput: one word per cycle; busy is always low (input, shift, result registers).
// Reset: synchronous rst clears the valid pipeline; no done follows until new words.
// done marks result for one cycle; the receiver cannot stall.
module float_to_int64_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic        signed_mode,
  input  logic [63:0] mantissa_word,
  input  logic [15:0] sign_exponent,
  output logic        done,
  output logic [63:0] result
);

  logic          in_vld;
  logic          mid_vld;
  logic [1:0]    kind_q;
  logic          smode_q;
  logic [63:0]   mant_q;
  logic [15:0]   se_q;
  f2i_pkg::dec_t dec;
  f2i_pkg::mag_t mag;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      mid_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      in_vld <= start && !busy;
      mid_vld <= in_vld;
      done <= mid_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_q <= kind;
      smode_q <= signed_mode;
      mant_q <= mantissa_word;
      se_q <= sign_exponent;
    end
  end

  f2i_decode u_decode (
    .kind          (kind_q),
    .signed_mode   (smode_q),
    .mantissa_word (mant_q),
    .sign_exponent (se_q),
    .dec           (dec)
  );

  f2i_shift u_shift (
    .clk (clk),
    .dec (dec),
    .mag (mag)
  );

  f2i_finish u_finish (
    .clk    (clk),
    .mag    (mag),
    .result (result)
  );

endmodule
